[src/bgc_pkg.sv]
`default_nettype none
package bgc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned EvW    = 3;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDoubleTap = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHold      = 2'd2;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] DoubleTapRst = 16'd300;
  localparam logic [CfgW-1:0] HoldRst      = 16'd301;

  localparam logic [EvW-1:0] EvNone   = 3'd0;
  localparam logic [EvW-1:0] EvTap    = 3'd1;
  localparam logic [EvW-1:0] EvDouble = 3'd2;
  localparam logic [EvW-1:0] EvHold   = 3'd3;
  localparam logic [EvW-1:0] EvLetGo  = 3'd4;

  typedef struct packed {
    logic             level;
    logic [TimeW-1:0] now_ms;
    logic             remote_on;
  } in_t;

  typedef struct packed {
    logic [EvW-1:0] event_res;
    logic           relay_on;
  } out_t;

endpackage
`default_nettype wire

[src/button_gesture_classifier.sv]
// Button gesture classifier: takes one sample per request (active-low raw level, wrapping
// millisecond timestamp, remote-on) and returns one result per sample with an event code
// (none, tap, double tap, hold, let-go) and the relay drive. A new request is taken every
// clock cycle while the output is not stalled. Each result passes through the input
// register, then the result register; an output stall holds the sample in the input register.
// Gesture state is updated in the same cycle that the sample leaves the input register, so a
// sample always sees the state left by the one before it. The user must write the timing
// registers on the cfg port only while no request is in flight; the block itself does not
// enforce it. Indexes beyond hold_ms are ignored.
`default_nettype none
module button_gesture_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire bgc_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output bgc_pkg::out_t                    out_data,
  input  wire logic                        cfg_we,
  input  wire logic [bgc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [bgc_pkg::CfgW-1:0]    cfg_wdata
);

  logic [bgc_pkg::CfgW-1:0] debounce_r, double_tap_r, hold_r;

  logic          s1_valid_r;
  bgc_pkg::in_t  s1_r;
  logic          out_valid_r;
  bgc_pkg::out_t out_r;

  logic                      last_level_r;
  logic [bgc_pkg::TimeW-1:0] edge_time_r, tap_start_r, press_time_r;
  logic                      pressed_r, double_armed_r, held_r;

  logic                      last_level_nxt;
  logic [bgc_pkg::TimeW-1:0] edge_time_nxt, tap_start_nxt, press_time_nxt;
  logic                      pressed_nxt, double_armed_nxt, held_nxt;
  bgc_pkg::out_t             out_nxt;

  logic                      out_ready, proc, s1_load;
  logic [bgc_pkg::TimeW-1:0] d_edge, d_tap, d_press;
  logic                      deb_ok, press_e, rel_e, hold_e;

  assign out_ready = !out_valid_r || !out_stall;
  assign proc      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign s1_load   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign d_edge  = s1_r.now_ms - edge_time_r;
  assign d_tap   = s1_r.now_ms - tap_start_r;
  assign d_press = s1_r.now_ms - press_time_r;
  assign deb_ok  = d_edge > {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, debounce_r};
  assign press_e = !s1_r.level && last_level_r && deb_ok;
  assign rel_e   = s1_r.level && !last_level_r && deb_ok;

  always_comb begin
    last_level_nxt   = s1_r.level;
    edge_time_nxt    = edge_time_r;
    tap_start_nxt    = tap_start_r;
    press_time_nxt   = press_time_r;
    pressed_nxt      = pressed_r;
    double_armed_nxt = double_armed_r;
    held_nxt         = held_r;
    out_nxt.event_res = bgc_pkg::EvNone;
    hold_e           = 1'b0;

    if (press_e) begin
      edge_time_nxt    = s1_r.now_ms;
      press_time_nxt   = s1_r.now_ms;
      tap_start_nxt    = s1_r.now_ms;
      pressed_nxt      = 1'b1;
      double_armed_nxt = d_tap < {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, double_tap_r};
    end

    if (rel_e) begin
      edge_time_nxt = s1_r.now_ms;
      pressed_nxt   = 1'b0;
      if (double_armed_r) begin
        out_nxt.event_res = bgc_pkg::EvDouble;
        double_armed_nxt  = 1'b0;
        tap_start_nxt     = '0;
      end else if (d_press < {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, hold_r}) begin
        out_nxt.event_res = bgc_pkg::EvTap;
      end else begin
        out_nxt.event_res = bgc_pkg::EvLetGo;
        held_nxt          = 1'b0;
      end
    end

    // a fresh press has zero elapsed time
    if (press_e) begin
      hold_e = hold_r == '0;
    end else begin
      hold_e = pressed_nxt &&
               (d_press >= {{(bgc_pkg::TimeW-bgc_pkg::CfgW){1'b0}}, hold_r});
    end

    if (hold_e) begin
      out_nxt.event_res = bgc_pkg::EvHold;
      pressed_nxt       = 1'b0;
      held_nxt          = 1'b1;
      tap_start_nxt     = '0;
      press_time_nxt    = '0;
    end

    out_nxt.relay_on = s1_r.remote_on || pressed_nxt || held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= bgc_pkg::DebounceRst;
      double_tap_r   <= bgc_pkg::DoubleTapRst;
      hold_r         <= bgc_pkg::HoldRst;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      last_level_r   <= 1'b1;
      edge_time_r    <= '0;
      tap_start_r    <= '0;
      press_time_r   <= '0;
      pressed_r      <= 1'b0;
      double_armed_r <= 1'b0;
      held_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bgc_pkg::CfgDebounce:  debounce_r   <= cfg_wdata;
          bgc_pkg::CfgDoubleTap: double_tap_r <= cfg_wdata;
          bgc_pkg::CfgHold:      hold_r       <= cfg_wdata;
          default: ;
        endcase
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= proc;
      end
      if (proc) begin
        last_level_r   <= last_level_nxt;
        edge_time_r    <= edge_time_nxt;
        tap_start_r    <= tap_start_nxt;
        press_time_r   <= press_time_nxt;
        pressed_r      <= pressed_nxt;
        double_armed_r <= double_armed_nxt;
        held_r         <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= in_data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !proc |=> $stable(pressed_r) && $stable(held_r) && $stable(edge_time_r))
    else $error("gesture state changed without a request");

  a_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> last_level_r == $past(s1_r.level))
    else $error("last level did not follow processed sample");

  a_hold_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_res == bgc_pkg::EvHold |-> out_r.relay_on)
    else $error("hold event without relay drive");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.event_res <= bgc_pkg::EvLetGo)
    else $error("event code out of range");

endmodule
`default_nettype wire

[test/button_gesture_classifier_tb.sv]
`timescale 1ns / 100ps
module button_gesture_classifier_tb;

  localparam logic [bgc_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum logic [1:0] {
    StallNever,
    StallSome,
    StallHeavy
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bgc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bgc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [bgc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bgc_pkg::CfgW-1:0] cfg_wdata = '0;

  button_gesture_classifier u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gesture state and timing of the predictor
  logic [bgc_pkg::CfgW-1:0] debounce_cfg;
  logic [bgc_pkg::CfgW-1:0] dbltap_cfg;
  logic [bgc_pkg::CfgW-1:0] hold_cfg;
  logic btn_last;
  logic [bgc_pkg::TimeW-1:0] edge_ms;
  logic [bgc_pkg::TimeW-1:0] tap_start_ms;
  logic [bgc_pkg::TimeW-1:0] press_ms;
  logic is_pressed;
  logic dbl_armed;
  logic is_held;

  bgc_pkg::in_t sample_q[$];
  bgc_pkg::out_t expected_results[$];
  bgc_pkg::out_t exp_res;
  int unsigned queued_cnt = 0;
  int unsigned errs = 0;
  logic [bgc_pkg::TimeW-1:0] stim_ms;
  logic drv_pause = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_t stall_mode = StallNever;
  int unsigned mode_left = 0;

  function automatic bgc_pkg::out_t classify(bgc_pkg::in_t smp);
    logic [bgc_pkg::EvW-1:0] ev;
    logic [bgc_pkg::TimeW-1:0] since_edge;
    logic [bgc_pkg::TimeW-1:0] since_tap;
    logic [bgc_pkg::TimeW-1:0] since_press;
    bgc_pkg::out_t res;
    ev = bgc_pkg::EvNone;
    since_edge = smp.now_ms - edge_ms;
    since_tap = smp.now_ms - tap_start_ms;
    if (!smp.level && btn_last && since_edge > debounce_cfg) begin
      edge_ms = smp.now_ms;
      press_ms = smp.now_ms;
      is_pressed = 1'b1;
      dbl_armed = since_tap < dbltap_cfg;
      tap_start_ms = smp.now_ms;
    end
    if (smp.level && !btn_last && since_edge > debounce_cfg) begin
      edge_ms = smp.now_ms;
      since_press = smp.now_ms - press_ms;
      if (dbl_armed) begin
        ev = bgc_pkg::EvDouble;
        dbl_armed = 1'b0;
        tap_start_ms = '0;
      end else if (since_press < hold_cfg) begin
        ev = bgc_pkg::EvTap;
      end else begin
        ev = bgc_pkg::EvLetGo;
        is_held = 1'b0;
      end
      is_pressed = 1'b0;
    end
    since_press = smp.now_ms - press_ms;
    if (is_pressed && since_press >= hold_cfg) begin
      ev = bgc_pkg::EvHold;
      is_pressed = 1'b0;
      is_held = 1'b1;
      tap_start_ms = '0;
      press_ms = '0;
    end
    btn_last = smp.level;
    res.event_res = ev;
    res.relay_on = smp.remote_on | is_pressed | is_held;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(classify(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0 && !drv_pause) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        StallNever: out_stall <= 1'b0;
        StallSome: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errs++;
        if (errs <= 10) begin
          $display("unexpected result: event %0d relay %0b", out_data.event_res,
                   out_data.relay_on);
        end
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.event_res !== exp_res.event_res ||
            out_data.relay_on !== exp_res.relay_on) begin
          errs++;
          if (errs <= 10) begin
            $display("mismatch: event exp %0d got %0d, relay exp %0b got %0b",
                     exp_res.event_res, out_data.event_res, exp_res.relay_on,
                     out_data.relay_on);
          end
        end
      end
    end
  end

  function automatic logic pick_remote();
    return $urandom_range(0, 4) == 0;
  endfunction

  function automatic int unsigned near_value(int unsigned x);
    case ($urandom_range(0, 5))
      0: return (x > 0) ? x - 1 : 0;
      1: return x;
      2: return x + 1;
      3: return $urandom_range(0, x);
      4: return x + $urandom_range(2, 40);
      default: return $urandom_range(0, 2 * x + 2);
    endcase
  endfunction

  task automatic push_sample(logic lvl, logic [bgc_pkg::TimeW-1:0] t, logic rem);
    bgc_pkg::in_t smp;
    smp.level = lvl;
    smp.now_ms = t;
    smp.remote_on = rem;
    sample_q.push_back(smp);
    queued_cnt++;
  endtask

  // chatter inside the debounce window, settling at the rest level
  task automatic bounce(logic rest, int unsigned deb);
    int unsigned n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      push_sample(~rest ^ i[0], stim_ms + $urandom_range(0, deb), pick_remote());
    end
    if (n != 0) begin
      push_sample(rest, stim_ms + deb, pick_remote());
    end
  endtask

  task automatic queue_gesture();
    int unsigned deb;
    int unsigned dur;
    int unsigned to_next;
    int unsigned m;
    logic [bgc_pkg::TimeW-1:0] press_at;
    deb = debounce_cfg;
    press_at = stim_ms;
    push_sample(1'b0, stim_ms, pick_remote());
    bounce(1'b0, deb);
    if ($urandom_range(0, 1) == 0) begin
      dur = near_value(hold_cfg);
    end else begin
      dur = $urandom_range(0, dbltap_cfg);
    end
    if (dur <= deb && $urandom_range(0, 7) != 0) begin
      dur = deb + 1 + $urandom_range(0, 3);
    end
    m = $urandom_range(0, 3);
    for (int k = 1; k <= m; k++) begin
      push_sample(1'b0, press_at + dur * k / (m + 1), pick_remote());
    end
    if ($urandom_range(0, 2) == 0 && hold_cfg < dur) begin
      push_sample(1'b0, press_at + hold_cfg, pick_remote());
    end
    stim_ms = press_at + dur;
    push_sample(1'b1, stim_ms, pick_remote());
    bounce(1'b1, deb);
    to_next = near_value(dbltap_cfg);
    if (to_next <= dur + deb && $urandom_range(0, 7) != 0) begin
      to_next = dur + deb + 1 + $urandom_range(0, 3);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_sample(1'b1, stim_ms + $urandom_range(0, to_next), pick_remote());
    end
    stim_ms = press_at + to_next;
  endtask

  task automatic queue_gestures(int unsigned n);
    int unsigned target;
    target = queued_cnt + n;
    while (queued_cnt < target) begin
      case ($urandom_range(0, 19))
        0: begin
          push_sample(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) == 0) ? $urandom
                                                  : stim_ms + $urandom_range(0, 2 * hold_cfg),
                      pick_remote());
        end
        1: begin
          stim_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * hold_cfg + 3);
          queue_gesture();
        end
        default: queue_gesture();
      endcase
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bgc_pkg::CfgIdxW-1:0] idx, logic [bgc_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bgc_pkg::CfgDebounce: debounce_cfg = val;
      bgc_pkg::CfgDoubleTap: dbltap_cfg = val;
      bgc_pkg::CfgHold: hold_cfg = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [bgc_pkg::CfgW-1:0] deb, logic [bgc_pkg::CfgW-1:0] dbl,
                           logic [bgc_pkg::CfgW-1:0] hld, logic pause_mid);
    drain();
    write_reg(bgc_pkg::CfgDebounce, deb);
    write_reg(bgc_pkg::CfgDoubleTap, dbl);
    write_reg(bgc_pkg::CfgHold, hld);
    write_reg(CfgSpare, bgc_pkg::CfgW'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    queue_gestures(145);
    if (pause_mid) begin
      while (sample_q.size() > 20) @(negedge clk);
      @(posedge clk);
      drv_pause <= 1'b1;
      do @(negedge clk);
      while (in_valid || expected_results.size() != 0);
      @(posedge clk);
      drv_pause <= 1'b0;
    end
    queue_gestures(145);
  endtask

  initial begin
    debounce_cfg = bgc_pkg::DebounceRst;
    dbltap_cfg = bgc_pkg::DoubleTapRst;
    hold_cfg = bgc_pkg::HoldRst;
    btn_last = 1'b1;
    edge_ms = '0;
    tap_start_ms = '0;
    press_ms = '0;
    is_pressed = 1'b0;
    dbl_armed = 1'b0;
    is_held = 1'b0;
    stim_ms = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // tap, double tap, hold, let-go, lost edges and the timestamp wrap
    push_sample(1'b1, 32'd0, 1'b0);
    push_sample(1'b0, 32'd100, 1'b1);
    push_sample(1'b1, 32'd120, 1'b0);
    push_sample(1'b0, 32'd130, 1'b0);
    push_sample(1'b1, 32'd400, 1'b0);
    push_sample(1'b0, 32'd1000, 1'b0);
    push_sample(1'b1, 32'd1100, 1'b0);
    push_sample(1'b0, 32'd1200, 1'b0);
    push_sample(1'b0, 32'd1600, 1'b0);
    push_sample(1'b1, 32'd1700, 1'b0);
    push_sample(1'b1, 32'd2000, 1'b1);
    push_sample(1'b0, 32'd2500, 1'b0);
    push_sample(1'b1, 32'd2900, 1'b0);
    push_sample(1'b0, 32'd3500, 1'b0);
    push_sample(1'b0, 32'd3900, 1'b0);
    push_sample(1'b1, 32'd4000, 1'b0);
    push_sample(1'b0, 32'hFFFF_FF00, 1'b1);
    push_sample(1'b0, 32'hFFFF_FFFF, 1'b0);
    push_sample(1'b1, 32'h0000_0040, 1'b1);
    push_sample(1'b0, 32'h0000_0050, 1'b0);
    push_sample(1'b1, 32'h0000_0100, 1'b0);
    push_sample(1'b0, 32'h8000_0000, 1'b1);
    push_sample(1'b1, 32'hFFFF_FFFF, 1'b0);
    push_sample(1'b0, 32'h0000_0000, 1'b0);

    queue_gestures(280);
    run_phase(16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(16'd5, 16'd40, 16'd60, 1'b1);
    run_phase(bgc_pkg::CfgW'($urandom_range(0, 200)), bgc_pkg::CfgW'($urandom_range(0, 2000)),
              bgc_pkg::CfgW'($urandom_range(0, 1000)), 1'b0);
    run_phase(bgc_pkg::CfgW'($urandom_range(0, 65535)), bgc_pkg::CfgW'($urandom_range(0, 65535)),
              bgc_pkg::CfgW'($urandom_range(0, 65535)), 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (errs == 0) begin
      $display("button_gesture_classifier_tb: done, clean");
    end else begin
      $display("button_gesture_classifier_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("button_gesture_classifier_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
src/bgc_pkg.sv
src/button_gesture_classifier.sv
test/button_gesture_classifier_tb.sv
